[rtl/i2cm_pkg.sv]
// Shared types, command codes and helper functions for the I2C master bit engine.
package i2cm_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned StepW  = 5;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned InW    = 16;
  localparam int unsigned OutW   = 16;

  localparam logic [ByteW-1:0] MsbMask = 8'h80;

  typedef enum logic [ModeW-1:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_SACK  = 3'd5,
    CMD_RACK  = 3'd6
  } cmd_t;

  localparam logic [PhaseW-1:0] PH_DATA  = 2'd0;
  localparam logic [PhaseW-1:0] PH_HIGH  = 2'd1;
  localparam logic [PhaseW-1:0] PH_LOW   = 2'd2;

  // Engine state carried from one word to the next.
  typedef struct packed {
    logic              scl;
    logic              sda;
    cmd_t              cmd;
    logic [StepW-1:0]  step;
    logic [PhaseW-1:0] phase;
    logic [ByteW-1:0]  shift;
    logic              ack;
  } state_t;

  // Input word fields.
  typedef struct packed {
    logic             sda_in;
    logic             ack_to_send;
    logic [ByteW-1:0] tx_byte;
    logic [ModeW-1:0] mode;
  } in_t;

  // Result word fields.
  typedef struct packed {
    logic             cmd_rejected;
    logic             ack_received;
    logic [ByteW-1:0] rx_byte;
    logic             done_res;
    logic             busy_res;
    logic             sda_out;
    logic             scl_out;
  } res_t;

  function automatic logic [StepW-1:0] last_step(input cmd_t cmd);
    logic [StepW-1:0] r;
    case (cmd)
      CMD_START: r = 5'd3;
      CMD_STOP:  r = 5'd2;
      CMD_SEND:  r = 5'd23;
      CMD_RECV:  r = 5'd24;
      CMD_SACK:  r = 5'd2;
      CMD_RACK:  r = 5'd3;
      default:   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [PhaseW-1:0] phase_inc(input logic [PhaseW-1:0] ph);
    logic [PhaseW-1:0] r;
    if (ph == PH_LOW) r = PH_DATA;
    else r = ph + 2'd1;
    return r;
  endfunction

endpackage

[rtl/i2cm_step.sv]
// Combinational action logic: one bus tick applied to the engine state.
module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  i2cm_pkg::in_t    din,
  output i2cm_pkg::state_t st_next,
  output i2cm_pkg::res_t   res
);
  import i2cm_pkg::*;

  logic             is_cmd;
  logic             idle;
  state_t           cur;
  logic [StepW-1:0] s;
  logic             last;

  always_comb begin
    is_cmd = (din.mode != ModeW'(CMD_NONE)) && (din.mode != 3'd7);
    idle   = (st.cmd == CMD_NONE);
    cur    = st;

    // An idle engine takes the command and performs its first action now.
    if (idle && is_cmd) begin
      cur.cmd   = cmd_t'(din.mode);
      cur.step  = '0;
      cur.phase = PH_DATA;
      if (din.mode == ModeW'(CMD_SEND)) cur.shift = din.tx_byte;
      if (din.mode == ModeW'(CMD_RECV)) cur.shift = '0;
    end

    s       = cur.step;
    st_next = cur;
    last    = (s >= last_step(cur.cmd));

    case (cur.cmd)
      CMD_START: begin
        if (s == 5'd0) st_next.sda = 1'b1;
        else if (s == 5'd1) st_next.scl = 1'b1;
        else if (s == 5'd2) st_next.sda = 1'b0;
        else st_next.scl = 1'b0;
      end
      CMD_STOP: begin
        if (s == 5'd0) st_next.sda = 1'b0;
        else if (s == 5'd1) st_next.scl = 1'b1;
        else st_next.sda = 1'b1;
      end
      CMD_SEND: begin
        st_next.phase = phase_inc(cur.phase);
        if (cur.phase == PH_DATA) begin
          st_next.sda   = |(cur.shift & MsbMask);
          st_next.shift = {cur.shift[ByteW-2:0], 1'b0};
        end else if (cur.phase == PH_HIGH) begin
          st_next.scl = 1'b1;
        end else begin
          st_next.scl = 1'b0;
        end
      end
      CMD_RECV: begin
        if (s == 5'd0) begin
          // Releasing SDA does not count in the data, high and low phases of a bit.
          st_next.sda = 1'b1;
        end else begin
          st_next.phase = phase_inc(cur.phase);
          if (cur.phase == PH_DATA) st_next.scl = 1'b1;
          else if (cur.phase == PH_HIGH) st_next.shift = {cur.shift[ByteW-2:0], din.sda_in};
          else st_next.scl = 1'b0;
        end
      end
      CMD_SACK: begin
        if (s == 5'd0) st_next.sda = din.ack_to_send;
        else if (s == 5'd1) st_next.scl = 1'b1;
        else st_next.scl = 1'b0;
      end
      CMD_RACK: begin
        if (s == 5'd0) st_next.sda = 1'b1;
        else if (s == 5'd1) st_next.scl = 1'b1;
        else if (s == 5'd2) st_next.ack = din.sda_in;
        else st_next.scl = 1'b0;
      end
      default: begin
      end
    endcase

    res              = '0;
    res.cmd_rejected = !idle && is_cmd;
    if (cur.cmd != CMD_NONE) begin
      if (last) begin
        res.done_res = 1'b1;
        if (cur.cmd == CMD_RECV) res.rx_byte = st_next.shift;
        if (cur.cmd == CMD_RACK) res.ack_received = st_next.ack;
        st_next.cmd  = CMD_NONE;
        st_next.step = '0;
      end else begin
        st_next.step = s + 5'd1;
      end
    end
    res.scl_out  = st_next.scl;
    res.sda_out  = st_next.sda;
    res.busy_res = (st_next.cmd != CMD_NONE);
  end

endmodule

[rtl/i2c_master_bit_engine.sv]
// Top level of the I2C master bit engine: state register, tick logic and result register.
//
// Each input word is one bus tick from the prescaler; the engine answers every
// tick with exactly one result word giving the SCL and SDA levels to drive
// (open drain, 1 means released), busy and done flags, the received byte or
// ack bit on the done tick of a receive, and a flag when a command arrived
// while another one was still running (that command is dropped).
// A command (start, stop, send byte, receive byte, send ack, receive ack) is
// taken only on a tick where the engine is idle, and that tick already drives
// the first action of the command.
// The result of a tick is computed from the current state and the input word
// and is registered in the result register at the accepting edge. Throughput is
// one word per clock while the result side is not stalled; the only loop is the
// state register fed back through the tick logic.
// When the receiver stalls, the held result word blocks input only if it is
// not taken in the same cycle, so the input side keeps moving as long as
// m_tready is high. Reset (rst, synchronous, active high) releases both lines,
// returns the engine to idle and clears m_tvalid, leaving no result word held.
module i2c_master_bit_engine (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // [2:0] mode, [10:3] tx_byte, [11] ack_to_send, [12] sda_in, [15:13] zero
  input  logic [i2cm_pkg::InW-1:0]  s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte,
  // [12] ack_received, [13] cmd_rejected, [15:14] zero
  output logic [i2cm_pkg::OutW-1:0] m_tdata
);
  import i2cm_pkg::*;

  state_t st;
  state_t st_next;
  in_t    din;
  res_t   res_next;
  res_t   res;
  logic   accept;

  assign din = in_t'(s_tdata[$bits(in_t)-1:0]);

  i2cm_step u_step (
    .st      (st),
    .din     (din),
    .st_next (st_next),
    .res     (res_next)
  );

  // The result register may be refilled in the cycle its word is taken.
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.scl   <= 1'b1;
      st.sda   <= 1'b1;
      st.cmd   <= CMD_NONE;
      st.step  <= '0;
      st.phase <= PH_DATA;
      st.shift <= '0;
      st.ack   <= 1'b0;
    end else if (accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign m_tdata = {{(OutW - $bits(res_t)){1'b0}}, res};

  // An idle engine always sits at step zero.
  a_idle_step: assert property (@(posedge clk) disable iff (rst)
    (st.cmd == CMD_NONE) |-> (st.step == '0))
    else $error("idle engine with nonzero step count");

  // The bit phase counter never reaches its unused code.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    st.phase != 2'd3)
    else $error("bit phase out of range");

  // A done word never reports the engine as still busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.done_res) |-> !res.busy_res)
    else $error("done and busy in the same word");

  // Received data is zero outside a done word.
  a_rx_only_done: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !res.done_res) |-> (res.rx_byte == '0 && !res.ack_received))
    else $error("received data outside done word");

  // A command taken while idle is never flagged as rejected.
  a_no_reject_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && st.cmd == CMD_NONE) |=> !res.cmd_rejected)
    else $error("command rejected while idle");

endmodule
